>>> rtl/pzd_pkg.sv
// Shared types and constants for the polygon zone dwell checker.
// Used by every module in rtl; depends on nothing.
package pzd_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CNT_W   = 16;
  localparam int VCNT_W  = 5;
  localparam int IDX_W   = 4;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET  = 5'd0;
  localparam logic [CNT_W-1:0]  HOLD_TICKS_RESET    = 16'd50;
  localparam logic [CNT_W-1:0]  TIMEOUT_TICKS_RESET = 16'd300;
  localparam logic [CNT_W-1:0]  CNT_MAX             = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOADCUR,
    ST_MUL_L,
    ST_MUL_R,
    ST_CMP,
    ST_DONE
  } pzd_state_t;

  typedef struct packed {
    logic load_lhs;
    logic load_rhs;
  } pzd_mul_ctrl_t;

endpackage

>>> rtl/pzd_vtx_mem.sv
// Vertex table memory: one write port, one read port with registered data.
// Depends on pzd_pkg for the coordinate width.
module pzd_vtx_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [AW-1:0]                        wr_addr,
  input  logic signed [pzd_pkg::COORD_W-1:0]   wr_x,
  input  logic signed [pzd_pkg::COORD_W-1:0]   wr_y,
  input  logic [AW-1:0]                        rd_addr,
  output logic signed [pzd_pkg::COORD_W-1:0]   rd_x,
  output logic signed [pzd_pkg::COORD_W-1:0]   rd_y
);

  logic [2*pzd_pkg::COORD_W-1:0] mem [DEPTH];
  logic [2*pzd_pkg::COORD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
    rd_word_r <= mem[rd_addr];
  end

  assign rd_x = rd_word_r[2*pzd_pkg::COORD_W-1:pzd_pkg::COORD_W];
  assign rd_y = rd_word_r[pzd_pkg::COORD_W-1:0];

endmodule

>>> rtl/pzd_cross_unit.sv
// Edge crossing unit: one shared multiplier forms both cross products of an edge
// in turn, then a compare decides the crossing. Depends on pzd_pkg.
module pzd_cross_unit (
  input  logic                               clk,
  input  pzd_pkg::pzd_mul_ctrl_t             ctrl,
  input  logic signed [pzd_pkg::COORD_W-1:0] px,
  input  logic signed [pzd_pkg::COORD_W-1:0] py,
  input  logic signed [pzd_pkg::COORD_W-1:0] x1,
  input  logic signed [pzd_pkg::COORD_W-1:0] y1,
  input  logic signed [pzd_pkg::COORD_W-1:0] x2,
  input  logic signed [pzd_pkg::COORD_W-1:0] y2,
  output logic                               hit
);

  logic signed [pzd_pkg::DIFF_W-1:0] dpx, dpy, dx21, dy21;
  logic signed [pzd_pkg::DIFF_W-1:0] op_a, op_b;
  logic signed [pzd_pkg::PROD_W-1:0] prod;
  logic signed [pzd_pkg::PROD_W-1:0] lhs_r, rhs_r;
  logic                              straddle;

  assign dpx  = {px[pzd_pkg::COORD_W-1], px} - {x1[pzd_pkg::COORD_W-1], x1};
  assign dpy  = {py[pzd_pkg::COORD_W-1], py} - {y1[pzd_pkg::COORD_W-1], y1};
  assign dx21 = {x2[pzd_pkg::COORD_W-1], x2} - {x1[pzd_pkg::COORD_W-1], x1};
  assign dy21 = {y2[pzd_pkg::COORD_W-1], y2} - {y1[pzd_pkg::COORD_W-1], y1};

  assign op_a = ctrl.load_lhs ? dpx  : dx21;
  assign op_b = ctrl.load_lhs ? dy21 : dpy;
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.load_lhs) begin
      lhs_r <= prod;
    end
    if (ctrl.load_rhs) begin
      rhs_r <= prod;
    end
  end

  assign straddle = (y1 > py) != (y2 > py);
  assign hit = straddle && ((y2 > y1) ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

endmodule

>>> rtl/polygon_zone_dwell_checker_unit.sv
// Top level of the polygon zone dwell checker: sequencer, dwell tracking,
// configuration registers and output register.
// Depends on pzd_pkg, pzd_vtx_mem and pzd_cross_unit.
//
// Items enter on the in_ channel and each produces exactly one result on the
// out_ channel. A transfer happens when valid is high and stall is low.
// Load vertex writes one table slot, start check arms the dwell check, and a
// position sample runs the even-odd crossing test over the vertices in use.
// in_stall is low only while the sequencer is idle, so one item is in work
// at a time. A load, a start or a sample with no vertices goes straight to
// its result; a sample runs an edge loop of fetch, two multiplies on the
// shared multiplier and compare for each edge of the polygon.
// The output register holds a result while out_stall is high, and the next
// item can be accepted meanwhile; its result waits until the register frees.
// The configuration channel is always ready and takes a register index and
// data; the user must write it only while idle, which the block does not enforce.
// A synchronous active-low reset clears the check state and loads the
// register defaults; the vertex table is not cleared.
module polygon_zone_dwell_checker_unit #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [pzd_pkg::OP_W-1:0]               in_op,
  input  logic [pzd_pkg::IDX_W-1:0]              in_vertex_index,
  input  logic signed [pzd_pkg::COORD_W-1:0]     in_coord_x,
  input  logic signed [pzd_pkg::COORD_W-1:0]     in_coord_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_inside_res,
  output logic                                   out_settled,
  output logic                                   out_timed_out,
  output logic [pzd_pkg::CNT_W-1:0]              out_dwell_ticks,
  output logic                                   out_checking,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pzd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pzd_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pzd_pkg::pzd_state_t state_r, state_nxt;
  pzd_pkg::pzd_mul_ctrl_t mul_ctrl;

  logic [pzd_pkg::VCNT_W-1:0] vcount_r;
  logic [pzd_pkg::CNT_W-1:0]  hold_r, timeout_r;

  logic [pzd_pkg::OP_W-1:0]           op_r;
  logic signed [pzd_pkg::COORD_W-1:0] px_r, py_r;
  logic signed [pzd_pkg::COORD_W-1:0] first_x_r, first_y_r;
  logic signed [pzd_pkg::COORD_W-1:0] prev_x_r, prev_y_r;
  logic signed [pzd_pkg::COORD_W-1:0] cur_x_r, cur_y_r;
  logic signed [pzd_pkg::COORD_W-1:0] rd_x, rd_y;
  logic [CW-1:0]                      k_r;
  logic [CW-1:0]                      n_use;
  logic                               closing_r, parity_r;

  logic                       armed_r, armed_nxt;
  logic                       zone_r, zone_nxt;
  logic [pzd_pkg::CNT_W-1:0]  dwell_r, dwell_nxt;
  logic [pzd_pkg::CNT_W-1:0]  elapsed_r, elapsed_nxt;
  logic                       inside_c, settled_c, timed_c, over_c;

  logic          acc, first_ld, cur_ld, close_ld, cmp_en, done_ld;
  logic          wr_en, hit;
  logic [AW-1:0] rd_addr;
  logic          out_valid_r, out_inside_r, out_settled_r, out_timed_r, out_checking_r;
  logic [pzd_pkg::CNT_W-1:0] out_dwell_r;

  assign n_use = (32'(vcount_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_r);
  assign acc   = in_valid && !in_stall;
  assign wr_en = acc && (in_op == pzd_pkg::OP_LOAD) && (32'(in_vertex_index) < MAX_VERTICES);

  pzd_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_vertex_index)),
    .wr_x    (in_coord_x),
    .wr_y    (in_coord_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pzd_cross_unit u_cross (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .px   (px_r),
    .py   (py_r),
    .x1   (prev_x_r),
    .y1   (prev_y_r),
    .x2   (cur_x_r),
    .y2   (cur_y_r),
    .hit  (hit)
  );

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != pzd_pkg::ST_IDLE);
    rd_addr   = k_r[AW-1:0];
    mul_ctrl  = '0;
    first_ld  = 1'b0;
    cur_ld    = 1'b0;
    close_ld  = 1'b0;
    cmp_en    = 1'b0;
    done_ld   = 1'b0;
    unique case (state_r)
      pzd_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          if (in_op == pzd_pkg::OP_SAMPLE && n_use != '0) begin
            state_nxt = pzd_pkg::ST_FIRST;
          end else begin
            state_nxt = pzd_pkg::ST_DONE;
          end
        end
      end
      pzd_pkg::ST_FIRST: begin
        first_ld = 1'b1;
        if (k_r < n_use) begin
          state_nxt = pzd_pkg::ST_LOADCUR;
        end else begin
          state_nxt = pzd_pkg::ST_MUL_L;
        end
      end
      pzd_pkg::ST_LOADCUR: begin
        cur_ld    = 1'b1;
        state_nxt = pzd_pkg::ST_MUL_L;
      end
      pzd_pkg::ST_MUL_L: begin
        mul_ctrl.load_lhs = 1'b1;
        state_nxt = pzd_pkg::ST_MUL_R;
      end
      pzd_pkg::ST_MUL_R: begin
        mul_ctrl.load_rhs = 1'b1;
        state_nxt = pzd_pkg::ST_CMP;
      end
      pzd_pkg::ST_CMP: begin
        cmp_en = 1'b1;
        if (closing_r) begin
          state_nxt = pzd_pkg::ST_DONE;
        end else if (k_r < n_use) begin
          state_nxt = pzd_pkg::ST_LOADCUR;
        end else begin
          close_ld  = 1'b1;
          state_nxt = pzd_pkg::ST_MUL_L;
        end
      end
      pzd_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          done_ld   = 1'b1;
          state_nxt = pzd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pzd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    armed_nxt   = armed_r;
    zone_nxt    = zone_r;
    dwell_nxt   = dwell_r;
    elapsed_nxt = elapsed_r;
    settled_c   = 1'b0;
    timed_c     = 1'b0;
    over_c      = elapsed_r > timeout_r;
    inside_c    = (op_r == pzd_pkg::OP_SAMPLE) && parity_r;
    case (op_r)
      pzd_pkg::OP_START: begin
        armed_nxt   = 1'b1;
        zone_nxt    = 1'b0;
        dwell_nxt   = '0;
        elapsed_nxt = '0;
      end
      pzd_pkg::OP_SAMPLE: begin
        if (armed_r) begin
          if (elapsed_r != pzd_pkg::CNT_MAX) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
          if (!inside_c) begin
            zone_nxt  = 1'b0;
            dwell_nxt = '0;
          end else if (!zone_r) begin
            zone_nxt  = 1'b1;
            dwell_nxt = '0;
          end else if (dwell_r != pzd_pkg::CNT_MAX) begin
            dwell_nxt = dwell_r + 1'b1;
          end
          if (zone_nxt && dwell_nxt >= hold_r) begin
            settled_c = 1'b1;
            armed_nxt = 1'b0;
          end else if (over_c) begin
            timed_c   = 1'b1;
            armed_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pzd_pkg::ST_IDLE;
      vcount_r    <= pzd_pkg::VERTEX_COUNT_RESET;
      hold_r      <= pzd_pkg::HOLD_TICKS_RESET;
      timeout_r   <= pzd_pkg::TIMEOUT_TICKS_RESET;
      armed_r     <= 1'b0;
      zone_r      <= 1'b0;
      dwell_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pzd_pkg::REG_VERTEX_COUNT:  vcount_r  <= cfg_data[pzd_pkg::VCNT_W-1:0];
          pzd_pkg::REG_HOLD_TICKS:    hold_r    <= cfg_data;
          pzd_pkg::REG_TIMEOUT_TICKS: timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (done_ld) begin
        armed_r   <= armed_nxt;
        zone_r    <= zone_nxt;
        dwell_r   <= dwell_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (done_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r      <= in_op;
      px_r      <= in_coord_x;
      py_r      <= in_coord_y;
      k_r       <= CW'(1);
      closing_r <= 1'b0;
      parity_r  <= 1'b0;
    end
    if (first_ld) begin
      first_x_r <= rd_x;
      first_y_r <= rd_y;
      prev_x_r  <= rd_x;
      prev_y_r  <= rd_y;
      if (!(k_r < n_use)) begin
        cur_x_r   <= rd_x;
        cur_y_r   <= rd_y;
        closing_r <= 1'b1;
      end
    end
    if (cur_ld) begin
      cur_x_r <= rd_x;
      cur_y_r <= rd_y;
      k_r     <= k_r + 1'b1;
    end
    if (cmp_en) begin
      parity_r <= parity_r ^ hit;
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (close_ld) begin
      cur_x_r   <= first_x_r;
      cur_y_r   <= first_y_r;
      closing_r <= 1'b1;
    end
    if (done_ld) begin
      out_inside_r   <= inside_c;
      out_settled_r  <= settled_c;
      out_timed_r    <= timed_c;
      out_dwell_r    <= dwell_nxt;
      out_checking_r <= armed_nxt;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_inside_res  = out_inside_r;
  assign out_settled     = out_settled_r;
  assign out_timed_out   = out_timed_r;
  assign out_dwell_ticks = out_dwell_r;
  assign out_checking    = out_checking_r;

endmodule

>>> rtl/pzd_checker.sv
// Port-level checks for the polygon zone dwell checker, bound to the top level.
// Depends on pzd_pkg and polygon_zone_dwell_checker_unit.
module pzd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_inside_res,
  input logic                          out_settled,
  input logic                          out_timed_out,
  input logic [pzd_pkg::CNT_W-1:0]     out_dwell_ticks,
  input logic                          out_checking
);

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_settled && out_timed_out))
    else $error("settled and timed out reported together");

  a_event_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_settled || out_timed_out) |-> !out_checking)
    else $error("check still armed after settling or timing out");

  a_settled_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> out_inside_res)
    else $error("settled reported for a sample outside the zone");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the previous item finished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dwell_ticks))
    else $error("stalled result changed");

endmodule

bind polygon_zone_dwell_checker_unit pzd_checker u_pzd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_inside_res  (out_inside_res),
  .out_settled     (out_settled),
  .out_timed_out   (out_timed_out),
  .out_dwell_ticks (out_dwell_ticks),
  .out_checking    (out_checking)
);

>>> tb/polygon_zone_dwell_checker_unit_tb.sv
// Self-checking testbench for polygon_zone_dwell_checker_unit: random polygons,
// dwell and timeout episodes, random gaps and stalls, checked against a predictor.
// Depends on pzd_pkg and the RTL of polygon_zone_dwell_checker_unit.
`timescale 1ns / 100ps

module polygon_zone_dwell_checker_unit_tb;

  localparam int MAXV = 16;
  localparam logic [pzd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic signed [pzd_pkg::COORD_W-1:0] coord_t;
  typedef logic [MAXV-1:0][pzd_pkg::COORD_W-1:0] vtab_t;

  localparam coord_t COORD_MIN = 16'sh8000;
  localparam coord_t COORD_MAX = 16'sh7FFF;

  typedef struct {
    logic [pzd_pkg::OP_W-1:0]  op;
    logic [pzd_pkg::IDX_W-1:0] vidx;
    coord_t                    x;
    coord_t                    y;
    bit                        drain_first;
  } zone_item_t;

  typedef struct packed {
    logic                      inside_res;
    logic                      settled;
    logic                      timed_out;
    logic [pzd_pkg::CNT_W-1:0] dwell;
    logic                      checking;
  } zone_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pzd_pkg::OP_W-1:0] in_op = '0;
  logic [pzd_pkg::IDX_W-1:0] in_vertex_index = '0;
  coord_t in_coord_x = '0;
  coord_t in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_inside_res;
  logic out_settled;
  logic out_timed_out;
  logic [pzd_pkg::CNT_W-1:0] out_dwell_ticks;
  logic out_checking;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pzd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pzd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  polygon_zone_dwell_checker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_vertex_index(in_vertex_index), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_inside_res(out_inside_res),
    .out_settled(out_settled), .out_timed_out(out_timed_out),
    .out_dwell_ticks(out_dwell_ticks), .out_checking(out_checking),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state, updated at each accepted transfer.
  vtab_t vtx_x, vtx_y;
  bit zone_in = 1'b0;
  bit armed = 1'b0;
  logic [pzd_pkg::CNT_W-1:0] dwell_cnt = '0;
  logic [pzd_pkg::CNT_W-1:0] elapsed_cnt = '0;
  logic [pzd_pkg::VCNT_W-1:0] vcount_reg = pzd_pkg::VERTEX_COUNT_RESET;
  logic [pzd_pkg::CNT_W-1:0] hold_reg = pzd_pkg::HOLD_TICKS_RESET;
  logic [pzd_pkg::CNT_W-1:0] timeout_reg = pzd_pkg::TIMEOUT_TICKS_RESET;

  zone_item_t pending_items[$];
  zone_result_t dwell_expect[$];
  zone_item_t drv_item;
  zone_result_t want;
  bit in_fire = 1'b0;
  bit idle_on = 1'b1;
  int in_gap = 0;
  int stall_left = 0;
  int error_count = 0;
  int queued_count = 0;

  // Stimulus-side copy of the polygon, used to aim samples inside the zone.
  vtab_t plan_x, plan_y;
  int plan_count = 0;
  int plan_cx = 0;
  int plan_cy = 0;
  int plan_half = 1;
  int vc_plan [12] = '{4, 3, 16, 31, 1, 2, 5, 8, 6, 17, 12, 16};

  function automatic bit poly_contains(int count, vtab_t xs, vtab_t ys, coord_t px,
                                       coord_t py);
    int n, i, j;
    bit odd;
    longint x1, y1, x2, y2, dy, lhs, rhs;
    n = (count > MAXV) ? MAXV : count;
    odd = 1'b0;
    for (i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      x1 = $signed(xs[i]);
      y1 = $signed(ys[i]);
      x2 = $signed(xs[j]);
      y2 = $signed(ys[j]);
      if ((y1 > longint'(py)) != (y2 > longint'(py))) begin
        dy = y2 - y1;
        lhs = (longint'(px) - x1) * dy;
        rhs = (x2 - x1) * (longint'(py) - y1);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
      end
    end
    return odd;
  endfunction

  task automatic track_item(zone_item_t it);
    zone_result_t r;
    bit over;
    r = '0;
    case (it.op)
      pzd_pkg::OP_LOAD: begin
        vtx_x[it.vidx] = it.x;
        vtx_y[it.vidx] = it.y;
      end
      pzd_pkg::OP_START: begin
        armed = 1'b1;
        zone_in = 1'b0;
        dwell_cnt = '0;
        elapsed_cnt = '0;
      end
      pzd_pkg::OP_SAMPLE: begin
        r.inside_res = poly_contains(int'(vcount_reg), vtx_x, vtx_y, it.x, it.y);
        if (armed) begin
          over = elapsed_cnt > timeout_reg;
          if (elapsed_cnt != pzd_pkg::CNT_MAX) elapsed_cnt++;
          if (!r.inside_res) begin
            zone_in = 1'b0;
            dwell_cnt = '0;
          end else if (!zone_in) begin
            zone_in = 1'b1;
            dwell_cnt = '0;
          end else if (dwell_cnt != pzd_pkg::CNT_MAX) begin
            dwell_cnt++;
          end
          if (zone_in && dwell_cnt >= hold_reg) begin
            r.settled = 1'b1;
            armed = 1'b0;
          end else if (over) begin
            r.timed_out = 1'b1;
            armed = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.dwell = dwell_cnt;
    r.checking = armed;
    dwell_expect.insert(dwell_expect.size(), r);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    error_count++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (dwell_expect.size() == 0) begin
        report_mismatch("result transfer with nothing expected", 0, 0);
      end else begin
        want = dwell_expect.pop_front();
        if (out_inside_res !== want.inside_res)
          report_mismatch("inside_res", 32'(out_inside_res), 32'(want.inside_res));
        if (out_settled !== want.settled)
          report_mismatch("settled", 32'(out_settled), 32'(want.settled));
        if (out_timed_out !== want.timed_out)
          report_mismatch("timed_out", 32'(out_timed_out), 32'(want.timed_out));
        if (out_dwell_ticks !== want.dwell)
          report_mismatch("dwell_ticks", 32'(out_dwell_ticks), 32'(want.dwell));
        if (out_checking !== want.checking)
          report_mismatch("checking", 32'(out_checking), 32'(want.checking));
      end
    end
    if (rst_n && in_valid && !in_stall) track_item(drv_item);
    in_fire <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && dwell_expect.size() != 0)) begin
        drv_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op <= drv_item.op;
        in_vertex_index <= drv_item.vidx;
        in_coord_x <= drv_item.x;
        in_coord_y <= drv_item.y;
        in_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = gap_len();
    end
  end

  function automatic coord_t clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic coord_t near(int c, int h);
    return clamp16(c + int'($urandom_range(0, 2 * h)) - h);
  endfunction

  function automatic coord_t rnd_coord();
    int unsigned r;
    r = $urandom_range(0, 65535);
    return r[15:0];
  endfunction

  function automatic logic [pzd_pkg::IDX_W-1:0] rnd_index();
    int unsigned r;
    r = $urandom_range(0, MAXV - 1);
    return r[pzd_pkg::IDX_W-1:0];
  endfunction

  task automatic queue_item(logic [pzd_pkg::OP_W-1:0] op, logic [pzd_pkg::IDX_W-1:0] idx,
                            coord_t x, coord_t y);
    zone_item_t it;
    it.op = op;
    it.vidx = idx;
    it.x = x;
    it.y = y;
    it.drain_first = ($urandom_range(0, 99) < 2);
    if (op == pzd_pkg::OP_LOAD) begin
      plan_x[idx] = x;
      plan_y[idx] = y;
    end
    pending_items.insert(pending_items.size(), it);
    queued_count++;
  endtask

  task automatic pick_point(input int mode, output coord_t px, output coord_t py);
    int tries, used, slot;
    used = (plan_count > MAXV) ? MAXV : plan_count;
    case (mode)
      0: begin
        tries = 0;
        do begin
          px = near(plan_cx, plan_half);
          py = near(plan_cy, plan_half);
          tries++;
        end while (tries < 24 && !poly_contains(plan_count, plan_x, plan_y, px, py));
      end
      1: begin
        px = near(plan_cx, plan_half + plan_half / 2);
        py = near(plan_cy, plan_half + plan_half / 2);
      end
      2: begin
        px = rnd_coord();
        py = rnd_coord();
      end
      default: begin
        slot = (used > 0) ? $urandom_range(0, used - 1) : 0;
        px = plan_x[slot];
        py = plan_y[slot];
        if ($urandom_range(0, 1)) px = near(px, 8);
      end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || dwell_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [pzd_pkg::CFG_IDX_W-1:0] idx,
                           logic [pzd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pzd_pkg::REG_VERTEX_COUNT:  vcount_reg = data[pzd_pkg::VCNT_W-1:0];
      pzd_pkg::REG_HOLD_TICKS:    hold_reg = data;
      pzd_pkg::REG_TIMEOUT_TICKS: timeout_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int p, k, len, bias, mode, vc, n_used, shape, hv, tv, phase_start;
    coord_t px, py;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, idle and armed, with the reset register values.
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, 16'sd0, 16'sd0);
    queue_item(OP_UNUSED, 4'hF, COORD_MAX, COORD_MIN);
    queue_item(pzd_pkg::OP_START, 4'd0, COORD_MAX, COORD_MAX);
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, COORD_MIN, COORD_MAX);
    wait_idle();

    // Full-range square: corners, edges, horizontal edges, settle and timeout.
    cfg_write(pzd_pkg::REG_VERTEX_COUNT, 16'hFFE4);
    plan_count = 4;
    cfg_write(pzd_pkg::REG_HOLD_TICKS, 16'd1);
    cfg_write(pzd_pkg::REG_TIMEOUT_TICKS, 16'd3);
    queue_item(pzd_pkg::OP_LOAD, 4'd0, COORD_MIN, COORD_MIN);
    queue_item(pzd_pkg::OP_LOAD, 4'd1, COORD_MAX, COORD_MIN);
    queue_item(pzd_pkg::OP_LOAD, 4'd2, COORD_MAX, COORD_MAX);
    queue_item(pzd_pkg::OP_LOAD, 4'd3, COORD_MIN, COORD_MAX);
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, 16'sd0, 16'sd0);
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, COORD_MIN, COORD_MIN);
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, COORD_MAX, 16'sd0);
    queue_item(pzd_pkg::OP_SAMPLE, 4'd0, 16'sd0, COORD_MAX);
    queue_item(pzd_pkg::OP_START, 4'd0, 16'sd0, 16'sd0);
    repeat (3) queue_item(pzd_pkg::OP_SAMPLE, 4'd0, 16'sd0, 16'sd0);
    queue_item(pzd_pkg::OP_START, 4'd0, 16'sd0, 16'sd0);
    repeat (5) queue_item(pzd_pkg::OP_SAMPLE, 4'd0, 16'sd100, COORD_MAX);

    for (p = 0; p < 12; p++) begin
      wait_idle();
      idle_on = (p % 4 != 3);
      vc = vc_plan[p];
      cfg_write(pzd_pkg::REG_VERTEX_COUNT, vc[15:0]);
      plan_count = vc;
      hv = (p == 0) ? 0 : (p == 1) ? 65535 : $urandom_range(0, 20);
      cfg_write(pzd_pkg::REG_HOLD_TICKS, hv[15:0]);
      tv = (p == 2) ? 0 : (p == 3) ? 65535 : $urandom_range(0, 50);
      cfg_write(pzd_pkg::REG_TIMEOUT_TICKS, tv[15:0]);

      n_used = (vc > MAXV) ? MAXV : vc;
      plan_half = ($urandom_range(0, 3) == 0) ? $urandom_range(8000, 32767)
                                              : $urandom_range(4, 600);
      plan_cx = int'($urandom_range(0, 65535)) - 32768;
      plan_cy = int'($urandom_range(0, 65535)) - 32768;
      shape = $urandom_range(0, 2);
      for (k = 0; k < n_used; k++) begin
        if (shape == 2 && n_used == 4) begin
          px = clamp16((k == 1 || k == 2) ? plan_cx + plan_half : plan_cx - plan_half);
          py = clamp16((k >= 2) ? plan_cy + plan_half : plan_cy - plan_half);
        end else if (shape == 1) begin
          px = clamp16(plan_cx + (int'($urandom_range(0, 6)) - 3) * plan_half / 3);
          py = clamp16(plan_cy + (int'($urandom_range(0, 6)) - 3) * plan_half / 3);
        end else begin
          px = near(plan_cx, plan_half);
          py = near(plan_cy, plan_half);
        end
        queue_item(pzd_pkg::OP_LOAD, k[pzd_pkg::IDX_W-1:0], px, py);
      end

      phase_start = queued_count;
      while (queued_count - phase_start < 125) begin
        queue_item(pzd_pkg::OP_START, rnd_index(), rnd_coord(), rnd_coord());
        len = $urandom_range(1, 60);
        bias = $urandom_range(50, 97);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 5) begin
            case ($urandom_range(0, 3))
              0: queue_item(OP_UNUSED, rnd_index(), rnd_coord(), rnd_coord());
              1: queue_item(pzd_pkg::OP_LOAD, rnd_index(), near(plan_cx, plan_half),
                            near(plan_cy, plan_half));
              2: queue_item(pzd_pkg::OP_START, rnd_index(), rnd_coord(), rnd_coord());
              default: begin
                pick_point(2, px, py);
                queue_item(pzd_pkg::OP_SAMPLE, rnd_index(), px, py);
              end
            endcase
          end else begin
            mode = ($urandom_range(0, 99) < bias) ? 0 : $urandom_range(1, 3);
            pick_point(mode, px, py);
            queue_item(pzd_pkg::OP_SAMPLE, rnd_index(), px, py);
          end
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("polygon_zone_dwell_checker_unit: match");
    else
      $display("polygon_zone_dwell_checker_unit: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("polygon_zone_dwell_checker_unit: mismatch");
    $finish;
  end

endmodule
